>>> design/sdfes_pkg.sv
package sdfes_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 1024;
  localparam int unsigned PHI_W  = 32;
  localparam int unsigned EPS_W  = 31;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned REM_W  = 36;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RANK_DIV  = 20;
  localparam int unsigned RANK_SH   = 20;
  localparam int unsigned RANK_RCP  = ((1 << RANK_SH) + RANK_DIV - 1) / RANK_DIV;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGN_EPS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_BAND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_FALLB = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SQ,
    ST_DIV_MEAN,
    ST_DIV_SQ,
    ST_SEL,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [SQ_W-1:0]    rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } root_t;

endpackage

>>> design/sdfes_ram.sv
module sdfes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/sdfes_div.sv
module sdfes_div import sdfes_pkg::*; #(
  parameter int unsigned DivW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SQ_W-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [SQ_W-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(SQ_W);

  logic             busy_q, done_q;
  logic [StepW-1:0] cnt_q;
  logic [SQ_W-1:0]  num_q;
  logic [DivW-1:0]  rem_q, den_q;
  logic [DivW:0]    rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, num_q[SQ_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepW'(SQ_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[SQ_W-2:0], ge};
      rem_q <= ge ? rem_sub[DivW-1:0] : rem_sh[DivW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

>>> design/sdfes_root_cell.sv
module sdfes_root_cell import sdfes_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  root_t cell_i,
  output root_t cell_o
);

  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge;
  logic              valid_q;
  logic [SQ_W-1:0]   rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  assign rem_sh = {cell_i.rem[REM_W-3:0], cell_i.rad[SQ_W-1:SQ_W-2]};
  assign trial  = {2'b00, cell_i.root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= {cell_i.rad[SQ_W-3:0], 2'b00};
    rem_q  <= ge ? rem_sh - trial : rem_sh;
    root_q <= {cell_i.root[ROOT_W-2:0], ge};
  end

  assign cell_o = {valid_q, rad_q, rem_q, root_q};

endmodule

>>> design/sdf_error_statistics.sv
// Error statistics over sets of reference and approximate Q16.16 distance pairs. Each item
// passes through accept, evaluate, then squared-error accumulate before the next is taken.
// On the item marked last, if any pair is finite, the block reports after a tail of two passes
// through the shared shift-subtract divider (mean, then mean square) and bitwise rank selection
// over the error RAM through its single read port; the percentile rank comes from a reciprocal
// multiply and the square root runs meanwhile in a 32-cell pipelined chain. The input stalls
// during that tail; a report may wait on the output while the next set starts.
module sdf_error_statistics import sdfes_pkg::*; #(
  parameter int unsigned MaxSamples = MAX_SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   ref_phi_i,
  input  logic                 ref_finite_i,
  input  logic signed [31:0]   approx_phi_i,
  input  logic                 approx_finite_i,
  input  logic                 query_failed_i,
  input  logic                 last_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [10:0]          sample_total_o,
  output logic [10:0]          finite_total_o,
  output logic [10:0]          fallback_total_o,
  output logic [10:0]          mismatch_total_o,
  output logic [10:0]          ambiguous_total_o,
  output logic [10:0]          near_total_o,
  output logic [10:0]          near_mismatch_total_o,
  output logic [31:0]          max_error_o,
  output logic signed [10:0]   worst_index_o,
  output logic [31:0]          mean_error_o,
  output logic [31:0]          rms_err_o,
  output logic [31:0]          p95_error_o
);

  localparam int unsigned CW    = $clog2(MaxSamples + 1);
  localparam int unsigned AW    = $clog2(MaxSamples);
  localparam int unsigned SumW  = PHI_W + CW;
  localparam int unsigned DivW  = (CW > 5) ? CW : 5;
  localparam int unsigned BitW  = $clog2(PHI_W);
  localparam int unsigned RankW = CW + RANK_SH;

  state_e state_q, state_d;

  logic [EPS_W-1:0] eps_q, band_q;
  logic             allow_q;

  logic signed [31:0] ref_q, apx_q;
  logic               ref_ok_q, apx_ok_q, failed_q, last_q;

  logic [CW-1:0] samples_q, finite_q, fallb_q, mism_q, ambig_q, near_q, nmism_q;
  logic [31:0]   largest_q;
  logic [AW-1:0] largest_idx_q;
  logic          largest_vld_q;
  logic [SumW-1:0] abs_sum_q;
  logic [SQ_W-1:0] sq_sum_q, sq_q;
  logic            sq_vld_q;

  logic [31:0] mean_q, rms_q, p95_q;

  // Evaluation
  logic               full, fin, strict, ambig, near;
  logic signed [32:0] apx_x, ref_x, eps_x, diff;
  logic [31:0]        err;
  logic [32:0]        ref_abs;
  logic               r_in, r_out, a_in, a_out;

  always_comb begin
    full   = samples_q == CW'(MaxSamples);
    ref_x  = {ref_q[31], ref_q};
    apx_x  = {apx_q[31], apx_q};
    fin    = ref_ok_q && apx_ok_q && !failed_q;
    if (failed_q && allow_q) begin
      apx_x = ref_x;
      fin   = ref_ok_q;
    end
    eps_x   = {2'b00, eps_q};
    diff    = ref_x - apx_x;
    err     = diff[32] ? 32'(-diff) : diff[31:0];
    ref_abs = ref_x[32] ? 33'(-ref_x) : 33'(ref_x);
    r_in    = ref_x < -eps_x;
    r_out   = ref_x > eps_x;
    a_in    = apx_x < -eps_x;
    a_out   = apx_x > eps_x;
    ambig   = !(r_in || r_out) || !(a_in || a_out);
    strict  = (r_in && a_out) || (r_out && a_in);
    near    = ref_abs <= {2'b00, band_q};
  end

  // Shared divider
  logic            div_start, div_done, div_go_q;
  logic [SQ_W-1:0] div_num, div_quot;
  logic [DivW-1:0] div_den;
  logic [CW-1:0]   n_m1;
  logic [RankW-1:0] rank_prod;

  assign n_m1      = finite_q - 1'b1;
  assign rank_prod = RankW'(n_m1) * RankW'(RANK_RCP);

  always_comb begin
    div_num = '0;
    div_den = DivW'(finite_q);
    case (state_q)
      ST_DIV_MEAN: div_num = SQ_W'(abs_sum_q);
      ST_DIV_SQ:   div_num = sq_sum_q;
      default:     div_num = '0;
    endcase
  end

  sdfes_div #(.DivW(DivW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_num), .divisor_i(div_den),
    .done_o(div_done), .quotient_o(div_quot)
  );

  // Square root chain
  root_t chain [ROOT_W+1];

  assign chain[0] = {(state_q == ST_DIV_SQ) && div_done, div_quot, {REM_W{1'b0}},
                     {ROOT_W{1'b0}}};

  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    sdfes_root_cell u_cell (.clk_i, .rst_ni, .cell_i(chain[g]), .cell_o(chain[g+1]));
  end

  // Error RAM and selection
  logic [31:0]   ram_rdata;
  logic          ram_we;
  logic [CW-1:0] sel_idx_q, sel_cnt_q, sel_k_q;
  logic [BitW-1:0] sel_bit_q;
  logic [31:0]   prefix_q;
  logic          rv_q, sel_done;
  logic [32:0]   hi_mask;
  logic          match, decide;

  assign ram_we = (state_q == ST_EVAL) && !full && fin;

  sdfes_ram #(.Width(32), .Depth(MaxSamples)) u_ram (
    .clk_i,
    .we_i(ram_we), .waddr_i(finite_q[AW-1:0]), .wdata_i(err),
    .raddr_i(sel_idx_q[AW-1:0]), .rdata_o(ram_rdata)
  );

  assign hi_mask  = {33{1'b1}} << ({1'b0, sel_bit_q} + 1'b1);
  assign match    = (((ram_rdata ^ prefix_q) & hi_mask[31:0]) == '0) && !ram_rdata[sel_bit_q];
  assign decide   = (state_q == ST_SEL) && (sel_idx_q == finite_q) && !rv_q;
  assign sel_done = decide && (sel_bit_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:     state_d = ST_SQ;
      ST_SQ: begin
        if (last_q) state_d = (finite_q == '0) ? ST_REPORT : ST_DIV_MEAN;
        else        state_d = ST_IDLE;
      end
      ST_DIV_MEAN: if (div_done) state_d = ST_DIV_SQ;
      ST_DIV_SQ:   if (div_done) state_d = ST_SEL;
      ST_SEL:      if (sel_done) state_d = ST_REPORT;
      ST_REPORT:   if (!out_valid_o || !out_stall_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o  = state_q != ST_IDLE;
    cfg_ready_o = 1'b1;
    div_start   = 1'b0;
    case (state_q)
      ST_DIV_MEAN, ST_DIV_SQ: div_start = !div_go_q;
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      eps_q   <= '0;
      band_q  <= '0;
      allow_q <= 1'b0;
      div_go_q <= 1'b0;
      rv_q    <= 1'b0;
      out_valid_o <= 1'b0;
      samples_q <= '0; finite_q <= '0; fallb_q <= '0; mism_q <= '0;
      ambig_q <= '0; near_q <= '0; nmism_q <= '0;
      largest_q <= '0; largest_vld_q <= 1'b0;
      abs_sum_q <= '0; sq_sum_q <= '0; sq_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SIGN_EPS:    eps_q   <= cfg_data_i[EPS_W-1:0];
          CFG_NEAR_BAND:   band_q  <= cfg_data_i[EPS_W-1:0];
          CFG_ALLOW_FALLB: allow_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (div_start) div_go_q <= 1'b1;
      else if (div_done) div_go_q <= 1'b0;
      if (state_q == ST_REPORT && state_d == ST_IDLE) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;

      sq_vld_q <= (state_q == ST_EVAL) && !full && fin;
      if (state_q == ST_EVAL && !full) begin
        samples_q <= samples_q + 1'b1;
        if (failed_q) fallb_q <= fallb_q + 1'b1;
        if (fin) begin
          finite_q  <= finite_q + 1'b1;
          abs_sum_q <= abs_sum_q + SumW'(err);
          if (err > largest_q) begin
            largest_q     <= err;
            largest_vld_q <= 1'b1;
          end
          if (ambig) ambig_q <= ambig_q + 1'b1;
          else if (strict) mism_q <= mism_q + 1'b1;
          if (near) begin
            near_q <= near_q + 1'b1;
            if (strict) nmism_q <= nmism_q + 1'b1;
          end
        end
      end
      if (state_q == ST_SQ && sq_vld_q) begin
        sq_sum_q <= ({1'b0, sq_sum_q} + {1'b0, sq_q}) > {1'b0, {SQ_W{1'b1}}} ?
                    {SQ_W{1'b1}} : sq_sum_q + sq_q;
      end

      if (state_q == ST_SEL) begin
        if (sel_idx_q != finite_q) rv_q <= 1'b1;
        else rv_q <= 1'b0;
      end

      if (state_q == ST_REPORT && state_d == ST_IDLE) begin
        samples_q <= '0; finite_q <= '0; fallb_q <= '0; mism_q <= '0;
        ambig_q <= '0; near_q <= '0; nmism_q <= '0;
        largest_q <= '0; largest_vld_q <= 1'b0;
        abs_sum_q <= '0; sq_sum_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      ref_q    <= ref_phi_i;
      apx_q    <= approx_phi_i;
      ref_ok_q <= ref_finite_i;
      apx_ok_q <= approx_finite_i;
      failed_q <= query_failed_i;
      last_q   <= last_sample_i;
    end
    if (state_q == ST_EVAL) begin
      sq_q <= err * err;
      if (!full && fin && err > largest_q) largest_idx_q <= samples_q[AW-1:0];
    end
    if (state_q == ST_DIV_MEAN && div_done) mean_q <= div_quot[31:0];
    if (chain[ROOT_W].valid) rms_q <= chain[ROOT_W].root;
    if (state_q == ST_DIV_SQ && div_done) begin
      sel_k_q   <= n_m1 - rank_prod[RANK_SH +: CW];
      sel_idx_q <= '0;
      sel_cnt_q <= '0;
      sel_bit_q <= BitW'(PHI_W - 1);
      prefix_q  <= '0;
    end
    if (state_q == ST_SEL) begin
      if (sel_idx_q != finite_q) sel_idx_q <= sel_idx_q + 1'b1;
      if (rv_q && match) sel_cnt_q <= sel_cnt_q + 1'b1;
      if (decide) begin
        if (sel_k_q >= sel_cnt_q) begin
          prefix_q[sel_bit_q] <= 1'b1;
          sel_k_q <= sel_k_q - sel_cnt_q;
        end
        sel_cnt_q <= '0;
        sel_idx_q <= '0;
        sel_bit_q <= sel_bit_q - 1'b1;
      end
    end
    if (state_q == ST_REPORT && state_d == ST_IDLE) begin
      sample_total_o        <= CNT_W'(samples_q);
      finite_total_o        <= CNT_W'(finite_q);
      fallback_total_o      <= CNT_W'(fallb_q);
      mismatch_total_o      <= CNT_W'(mism_q);
      ambiguous_total_o     <= CNT_W'(ambig_q);
      near_total_o          <= CNT_W'(near_q);
      near_mismatch_total_o <= CNT_W'(nmism_q);
      max_error_o           <= largest_q;
      worst_index_o         <= largest_vld_q ? CNT_W'(largest_idx_q) : {CNT_W{1'b1}};
      mean_error_o          <= (finite_q == '0) ? '0 : mean_q;
      rms_err_o             <= (finite_q == '0) ? '0 : rms_q;
      p95_error_o           <= (finite_q == '0) ? '0 : p95_q;
    end
    if (sel_done) p95_q <= (sel_k_q >= sel_cnt_q) ? (prefix_q | 32'd1) : prefix_q;
  end

endmodule
